### hw/rtl/nat_pkg.sv
// Types and codes shared by the neighbor aging table modules.
`timescale 1ns / 1ps

package nat_pkg;

    localparam int ADDR_W  = 48;
    localparam int TIME_W  = 32;
    localparam int RETRY_W = 8;
    localparam int EXP_W   = 16;

    localparam logic [1:0] CMD_REFRESH = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_SCAN    = 2'd2;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_PULL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    localparam logic CFG_EXPIRE = 1'b0;
    localparam logic CFG_RETRY  = 1'b1;

    typedef enum logic [1:0] {
        OP_REFRESH,
        OP_REMOVE,
        OP_SCAN,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  now;
    } nat_cmd_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  addr;
        logic [RETRY_W-1:0] retries;
        logic [TIME_W-1:0]  age;
        logic               last;
    } nat_res_t;

    typedef struct packed {
        logic [EXP_W-1:0]   expire;
        logic [RETRY_W-1:0] limit;
    } nat_cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  stamp;
        logic [RETRY_W-1:0] retries;
    } nat_entry_t;

endpackage

### hw/rtl/nat_front.sv
// Input side: accept words, decode the command, queue them for the engine.
`timescale 1ns / 1ps

module nat_front import nat_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [1:0]                s_tuser,   // [1:0] command
    input  logic [ADDR_W+TIME_W-1:0]  s_tdata,   // [47:0] address, [79:48] now_seconds
    output logic                      q_valid,
    output nat_cmd_t                  q_data,
    input  logic                      q_pop
);

    nat_cmd_t   buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    nat_cmd_t   decoded;

    always_comb begin
        unique case (s_tuser)
            CMD_REFRESH: decoded.op = OP_REFRESH;
            CMD_REMOVE:  decoded.op = OP_REMOVE;
            CMD_SCAN:    decoded.op = OP_SCAN;
            default:     decoded.op = OP_NOP;
        endcase
        decoded.addr = s_tdata[ADDR_W-1:0];
        decoded.now  = s_tdata[ADDR_W+TIME_W-1:ADDR_W];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

### hw/rtl/nat_engine.sv
// Back end: table storage, command execution, slot scan and result register.
`timescale 1ns / 1ps

module nat_engine import nat_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  nat_cfg_t cfg,
    input  logic     q_valid,
    input  nat_cmd_t q_data,
    output logic     q_pop,
    output logic     out_valid,
    output nat_res_t out_res,
    input  logic     out_ready
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_MATCH   = 6'b000010,
        ST_PICK    = 6'b000100,
        ST_SCAN_RD = 6'b001000,
        ST_SCAN_EV = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    nat_cmd_t           cmd_reg, cmd_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [DEPTH-1:0]   match_reg, match_next;
    logic [DEPTH-1:0]   free_reg, free_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    nat_res_t           res_reg, res_next;
    logic [ADDR_W-1:0]  slot_addr_reg [DEPTH];
    nat_entry_t         slot_mem [DEPTH];
    nat_entry_t         rd_data_reg;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    nat_entry_t         mem_wdata;
    logic               tab_we;

    logic               out_free;
    logic               match_any;
    logic               free_any;
    logic [IW-1:0]      pick_idx;
    logic               idx_last;
    logic [TIME_W-1:0]  age;
    logic               stale;
    logic               at_limit;

    function automatic logic [IW-1:0] lowest_set(input logic [DEPTH-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IW'(i);
            end
        end
        return r;
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign match_any = |match_reg;
    assign free_any  = |free_reg;
    assign pick_idx  = match_any ? lowest_set(match_reg) : lowest_set(free_reg);
    assign idx_last  = (idx_reg == IW'(DEPTH - 1));
    assign age       = cmd_reg.now - rd_data_reg.stamp;
    assign stale     = valid_reg[idx_reg] && !(cmd_reg.now < rd_data_reg.stamp)
                       && (age >= {{(TIME_W-EXP_W){1'b0}}, cfg.expire});
    assign at_limit  = (rd_data_reg.retries >= cfg.limit);

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match_next[i] = valid_reg[i] && (slot_addr_reg[i] == cmd_reg.addr);
        end
        free_next = ~valid_reg;
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_waddr      = pick_idx;
        mem_wdata      = '{addr: cmd_reg.addr, stamp: cmd_reg.now, retries: '0};
        tab_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next = q_data;
                    idx_next = '0;
                    unique case (q_data.op)
                        OP_REFRESH, OP_REMOVE: state_next = ST_MATCH;
                        OP_SCAN:               state_next = ST_SCAN_RD;
                        default:               state_next = ST_DONE;
                    endcase
                end
            end
            ST_MATCH: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    res_next       = '{kind: KIND_DONE, addr: '0, retries: '0, age: '0,
                                       last: 1'b1};
                    state_next     = ST_IDLE;
                    if (cmd_reg.op == OP_REFRESH) begin
                        if (match_any) begin
                            mem_we = 1'b1;
                        end else if (free_any) begin
                            mem_we               = 1'b1;
                            tab_we               = 1'b1;
                            valid_next[pick_idx] = 1'b1;
                        end else begin
                            res_next.kind = KIND_FULL;
                            res_next.addr = cmd_reg.addr;
                        end
                    end else if (match_any) begin
                        valid_next[pick_idx] = 1'b0;
                    end
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                if (!stale || out_free) begin
                    if (stale) begin
                        out_valid_next = 1'b1;
                        res_next.addr  = rd_data_reg.addr;
                        res_next.age   = age;
                        res_next.last  = 1'b0;
                        if (at_limit) begin
                            res_next.kind       = KIND_EXPIRED;
                            res_next.retries    = rd_data_reg.retries;
                            valid_next[idx_reg] = 1'b0;
                        end else begin
                            res_next.kind     = KIND_PULL;
                            res_next.retries  = rd_data_reg.retries + RETRY_W'(1);
                            mem_we            = 1'b1;
                            mem_waddr         = idx_reg;
                            mem_wdata         = rd_data_reg;
                            mem_wdata.retries = rd_data_reg.retries + RETRY_W'(1);
                        end
                    end
                    if (idx_last) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    res_next       = '{kind: KIND_DONE, addr: '0, retries: '0, age: '0,
                                       last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        match_reg <= match_next;
        free_reg  <= free_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            slot_addr_reg[pick_idx] <= cmd_reg.addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

endmodule

### hw/rtl/neighbor_aging_table_core.sv
// Top level of the neighbor aging table: ports, configuration registers, front and engine.
//
// Input words carry a command in s_tuser and an address and time in s_tdata.
// Refresh stamps an address (adding it to the lowest free slot), remove frees it,
// scan visits every slot and reports stale entries as pull requests or removals.
// Every command ends with one result word with m_tlast high; a refused refresh
// on a full table gives a single table-full word instead of done.
// A two-word queue sits after the input, so s_tready stays high while the
// engine works or the receiver stalls, until the queue is full.
// Refresh and remove go from acceptance through queue pop, address compare across
// all slots, then slot pick and write. A scan visits each slot with a registered
// read of the slot memory, then an age test and update, and ends with done; a
// stalled receiver holds the engine.
// Reset empties the table through its valid bits at once and loads the
// expiry time 60 and retry limit 3; no clearing pass follows.
// Write configuration with cfg_wr_en only while no command is in flight.
`timescale 1ns / 1ps

module neighbor_aging_table_core import nat_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [1:0]                        s_tuser,   // [1:0] command
    input  logic [ADDR_W+TIME_W-1:0]          s_tdata,   // [47:0] address, [79:48] now_seconds
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [1:0]                        m_tuser,   // [1:0] kind
    output logic [ADDR_W+RETRY_W+TIME_W-1:0]  m_tdata,   // [47:0] entry_address,
                                                         // [55:48] retry_count,
                                                         // [87:56] age_seconds
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [EXP_W-1:0]                  cfg_wdata
);

    nat_cfg_t cfg_reg, cfg_next;
    logic     q_valid;
    nat_cmd_t q_data;
    logic     q_pop;
    nat_res_t res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXPIRE: cfg_next.expire = cfg_wdata;
                CFG_RETRY:  cfg_next.limit  = cfg_wdata[RETRY_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{expire: EXP_W'(60), limit: RETRY_W'(3)};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    nat_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    nat_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_res   (res),
        .out_ready (m_tready)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {res.age, res.retries, res.addr};
    assign m_tlast = res.last;

endmodule

### dv/neighbor_aging_table_core_tb.sv
// Self-checking testbench for the neighbor aging table core with a scoreboard class.
`timescale 1ns / 1ps

module neighbor_aging_table_core_tb;
    import nat_pkg::*;

    localparam int          SLOTS       = 16;
    localparam int          POOL        = 20;
    localparam int          CLK_PERIOD  = 8;
    localparam int unsigned STALL_LIMIT = 5000;

    class neighbor_table_tracker;
        bit                used[SLOTS];
        bit [ADDR_W-1:0]   addr_of[SLOTS];
        bit [TIME_W-1:0]   stamp_of[SLOTS];
        bit [RETRY_W-1:0]  tries_of[SLOTS];
        bit [EXP_W-1:0]    expire;
        bit [RETRY_W-1:0]  limit;
        nat_res_t          expected_results[$];
        int unsigned       mismatches;
        int unsigned       unexpected;
        int unsigned       commands;
        int unsigned       scans;
        int unsigned       words_out;
        int unsigned       kind_seen[4];

        function new();
            foreach (used[i]) used[i] = 1'b0;
            expire     = 16'd60;
            limit      = 8'd3;
            mismatches = 0;
            unexpected = 0;
            commands   = 0;
            scans      = 0;
            words_out  = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [EXP_W-1:0] value);
            if (idx == CFG_EXPIRE)
                expire = value;
            else
                limit = value[RETRY_W-1:0];
        endfunction

        function void push_word(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                                logic [RETRY_W-1:0] tries, logic [TIME_W-1:0] age,
                                logic last);
            nat_res_t w;
            w.kind    = kind;
            w.addr    = addr;
            w.retries = tries;
            w.age     = age;
            w.last    = last;
            expected_results.push_back(w);
        endfunction

        function int find_addr(logic [ADDR_W-1:0] addr);
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && addr_of[i] == addr)
                    return i;
            return -1;
        endfunction

        function void note_command(op_t op, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
            int                slot;
            logic [TIME_W-1:0] age;
            commands++;
            case (op)
                OP_REFRESH: begin
                    slot = find_addr(addr);
                    if (slot < 0) begin
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!used[i])
                                slot = i;
                        if (slot < 0) begin
                            push_word(KIND_FULL, addr, '0, '0, 1'b1);
                            return;
                        end
                        used[slot]    = 1'b1;
                        addr_of[slot] = addr;
                    end
                    stamp_of[slot] = now;
                    tries_of[slot] = '0;
                end
                OP_REMOVE: begin
                    slot = find_addr(addr);
                    if (slot >= 0)
                        used[slot] = 1'b0;
                end
                OP_SCAN: begin
                    scans++;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!used[i] || now < stamp_of[i])
                            continue;
                        age = now - stamp_of[i];
                        if (age < {16'd0, expire})
                            continue;
                        if (tries_of[i] >= limit) begin
                            used[i] = 1'b0;
                            push_word(KIND_EXPIRED, addr_of[i], tries_of[i], age, 1'b0);
                        end else begin
                            tries_of[i] = tries_of[i] + RETRY_W'(1);
                            push_word(KIND_PULL, addr_of[i], tries_of[i], age, 1'b0);
                        end
                    end
                end
                default: ;
            endcase
            push_word(KIND_DONE, '0, '0, '0, 1'b1);
        endfunction

        function void check_result(nat_res_t got);
            nat_res_t want;
            words_out++;
            if (expected_results.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("%0t: unexpected result kind %0d addr %h retries %0d age %0d last %0b",
                             $realtime, got.kind, got.addr, got.retries, got.age, got.last);
                return;
            end
            want = expected_results.pop_front();
            kind_seen[want.kind]++;
            if (got.kind !== want.kind || got.addr !== want.addr ||
                got.retries !== want.retries || got.age !== want.age ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display("%0t: mismatch exp kind %0d addr %h retries %0d age %0d last %0b, %s",
                             $realtime, want.kind, want.addr, want.retries, want.age, want.last,
                             $sformatf("got kind %0d addr %h retries %0d age %0d last %0b",
                                       got.kind, got.addr, got.retries, got.age, got.last));
            end
        endfunction
    endclass

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [1:0]                       s_tuser   = OP_REFRESH;
    logic [ADDR_W+TIME_W-1:0]         s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [1:0]                       m_tuser;
    logic [ADDR_W+RETRY_W+TIME_W-1:0] m_tdata;
    logic                             m_tlast;
    logic                             cfg_wr_en = 1'b0;
    logic                             cfg_index = CFG_EXPIRE;
    logic [EXP_W-1:0]                 cfg_wdata = '0;

    neighbor_table_tracker tracker = new();
    logic [ADDR_W-1:0]     pool[POOL];
    bit                    quiet      = 1'b0;
    int unsigned           hold_left  = 0;
    int unsigned           idle_count = 0;

    neighbor_aging_table_core #(
        .DEPTH(SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin : sink
        nat_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind    = m_tuser;
            got.addr    = m_tdata[47:0];
            got.retries = m_tdata[55:48];
            got.age     = m_tdata[87:56];
            got.last    = m_tlast;
            tracker.check_result(got);
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 10) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding",
                     tracker.expected_results.size());
            $display("neighbor_aging_table_core test failed");
            $finish;
        end
    end

    task automatic send_word(op_t op, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {now, addr};
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(op, addr, now);
    endtask

    task automatic drain(int unsigned settle);
        s_tvalid <= 1'b0;
        while (tracker.expected_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [EXP_W-1:0] value);
        drain(8);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_reg(idx, value);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(int count, int unsigned max_step, logic [TIME_W-1:0] start);
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] now;
        logic [ADDR_W-1:0] addr;
        op_t               op;
        int unsigned       pick;
        base = start;
        repeat (count) begin
            base = base + $urandom_range(0, max_step);
            now  = base;
            pick = $urandom_range(0, 15);
            if (pick == 0)
                now = $urandom;
            else if (pick == 1)
                now = base - $urandom_range(1, max_step + 1);
            addr = ($urandom_range(0, 4) == 0) ? ADDR_W'({$urandom, $urandom})
                                               : pool[$urandom_range(0, POOL - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_REFRESH;
            else if (pick < 60)
                op = OP_REMOVE;
            else if (pick < 95)
                op = OP_SCAN;
            else
                op = OP_NOP;
            send_word(op, addr, now);
        end
    endtask

    initial begin : stimulus
        foreach (pool[i]) pool[i] = ADDR_W'({$urandom, $urandom});
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(OP_SCAN, '0, '0);
        send_word(OP_REMOVE, 48'h0000_0000_0001, '0);
        send_word(OP_NOP, '1, '1);
        send_word(OP_REFRESH, '0, 32'd0);
        send_word(OP_REFRESH, '1, 32'd10);
        send_word(OP_REFRESH, '0, 32'd5);
        send_word(OP_SCAN, '0, 32'd4);
        repeat (4) send_word(OP_SCAN, '0, 32'd70);
        for (int i = 0; i < SLOTS; i++)
            send_word(OP_REFRESH, pool[i], 32'd100 + i);
        send_word(OP_REFRESH, pool[SLOTS], 32'd200);
        send_word(OP_SCAN, '0, '1);

        write_reg(CFG_EXPIRE, 16'd0);
        write_reg(CFG_RETRY, 16'd0);
        run_phase(60, 40, 32'hFFFF_F000);

        write_reg(CFG_EXPIRE, 16'hFFFF);
        write_reg(CFG_RETRY, 16'd255);
        run_phase(60, 40000, $urandom);

        write_reg(CFG_EXPIRE, 16'($urandom_range(1, 30)));
        write_reg(CFG_RETRY, 16'($urandom_range(1, 4)));
        run_phase(60, 12, $urandom);

        quiet = 1'b1;
        write_reg(CFG_EXPIRE, 16'd60);
        write_reg(CFG_RETRY, 16'd3);
        run_phase(60, 25, $urandom);

        drain(40);
        $display("Covered %0d commands (%0d scans) over five register settings, %0d result words",
                 tracker.commands, tracker.scans, tracker.words_out);
        $display("Saw %0d pull requests, %0d aged-out removals, %0d table-full refusals",
                 tracker.kind_seen[KIND_PULL], tracker.kind_seen[KIND_EXPIRED],
                 tracker.kind_seen[KIND_FULL]);
        if (tracker.mismatches + tracker.unexpected + tracker.expected_results.size() == 0) begin
            $display("neighbor_aging_table_core test passed");
        end else begin
            $display("Mismatches %0d, unexpected %0d", tracker.mismatches, tracker.unexpected);
            $display("neighbor_aging_table_core test failed");
        end
        $finish;
    end

endmodule
